### rtl/core/pcfm_pkg.sv
// Shared types, opcodes and phase codes of the period capture frequency meter.
package pcfm_pkg;

   localparam int DATA_BITS  = 32;
   localparam int COUNT_BITS = 16;
   localparam logic [DATA_BITS-1:0] REF_CLOCK_RESET = 32'd16000000;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] PHASE_WAIT_CODE = 2'd0;
   localparam logic [1:0] PHASE_MEAS_CODE = 2'd1;
   localparam logic [1:0] PHASE_DONE_CODE = 2'd2;

   typedef enum logic [2:0] {
      PH_WAIT = 3'b001,
      PH_MEAS = 3'b010,
      PH_DONE = 3'b100
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       edge_seen;
   } req_item_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] frequency_hz;
      logic [1:0]           phase_now;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]           phase_code;
      logic                 done;
      logic [DATA_BITS-1:0] elapsed;
   } status_type;

   function automatic logic [1:0] phase_to_code(input phase_type ph);
      logic [1:0] code;
      unique case (ph)
         PH_WAIT: code = PHASE_WAIT_CODE;
         PH_MEAS: code = PHASE_MEAS_CODE;
         PH_DONE: code = PHASE_DONE_CODE;
         default: code = PHASE_DONE_CODE;
      endcase
      return code;
   endfunction

endpackage

### rtl/core/pcfm_timer.sv
// Free-running timer, edge captures, overflow counter and measurement phase.
module pcfm_timer #(
   parameter int TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_accept,
   input  pcfm_pkg::req_item_type item,
   output pcfm_pkg::status_type  status
);

   logic [TIMER_BITS-1:0]          timer_ff, timer_in;
   logic [TIMER_BITS-1:0]          start_ff, start_in;
   logic [TIMER_BITS-1:0]          end_ff, end_in;
   logic [pcfm_pkg::COUNT_BITS-1:0] ovf_ff, ovf_in;
   logic [pcfm_pkg::COUNT_BITS-1:0] ovf_end_ff, ovf_end_in;
   pcfm_pkg::phase_type            phase_ff, phase_in;

   // Advance the timer and the capture state for one item
   always_comb begin
      timer_in   = timer_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      ovf_in     = ovf_ff;
      ovf_end_in = ovf_end_ff;
      phase_in   = phase_ff;
      if (item_accept) begin
         case (item.opcode)
            pcfm_pkg::OP_TICK: begin
               if (item.edge_seen) begin
                  unique case (phase_ff)
                     pcfm_pkg::PH_WAIT: begin
                        start_in = timer_ff;
                        ovf_in   = '0;
                        phase_in = pcfm_pkg::PH_MEAS;
                     end
                     pcfm_pkg::PH_MEAS: begin
                        end_in     = timer_ff;
                        ovf_end_in = ovf_ff;
                        phase_in   = pcfm_pkg::PH_DONE;
                     end
                     pcfm_pkg::PH_DONE: ;
                     default: ;
                  endcase
               end
               timer_in = timer_ff + 1'b1;
               if (timer_in == '0 && phase_in == pcfm_pkg::PH_MEAS) begin
                  ovf_in = ovf_in + 1'b1;
               end
            end
            pcfm_pkg::OP_START: begin
               start_in   = '0;
               end_in     = '0;
               ovf_in     = '0;
               ovf_end_in = '0;
               phase_in   = pcfm_pkg::PH_WAIT;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff   <= '0;
         start_ff   <= '0;
         end_ff     <= '0;
         ovf_ff     <= '0;
         ovf_end_ff <= '0;
         phase_ff   <= pcfm_pkg::PH_DONE;
      end else begin
         timer_ff   <= timer_in;
         start_ff   <= start_in;
         end_ff     <= end_in;
         ovf_ff     <= ovf_in;
         ovf_end_ff <= ovf_end_in;
         phase_ff   <= phase_in;
      end
   end

   // Elapsed tick count, kept exact modulo 2^32
   always_comb begin
      status.phase_code = pcfm_pkg::phase_to_code(phase_in);
      status.done       = (phase_ff == pcfm_pkg::PH_DONE);
      status.elapsed    = (pcfm_pkg::DATA_BITS'(ovf_end_ff) << TIMER_BITS)
                        + pcfm_pkg::DATA_BITS'(end_ff)
                        - pcfm_pkg::DATA_BITS'(start_ff);
   end

endmodule

### rtl/core/pcfm_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pcfm_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pcfm_pkg::DATA_BITS-1:0] dividend,
   input  logic [pcfm_pkg::DATA_BITS-1:0] divisor,
   output logic                           busy,
   output logic                           done,
   output logic [pcfm_pkg::DATA_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(pcfm_pkg::DATA_BITS);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [CNT_BITS-1:0]            cnt_ff, cnt_in;
   logic [pcfm_pkg::DATA_BITS-1:0] quo_ff, quo_in;
   logic [pcfm_pkg::DATA_BITS-1:0] rem_ff, rem_in;
   logic [pcfm_pkg::DATA_BITS-1:0] div_ff, div_in;
   logic [pcfm_pkg::DATA_BITS:0]   rem_shift;
   logic [pcfm_pkg::DATA_BITS:0]   diff;

   // Shift in the next dividend bit and try one subtract
   always_comb begin
      rem_shift = {rem_ff, quo_ff[pcfm_pkg::DATA_BITS-1]};
      diff      = rem_shift - {1'b0, div_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(pcfm_pkg::DATA_BITS - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[pcfm_pkg::DATA_BITS]) begin
            rem_in = diff[pcfm_pkg::DATA_BITS-1:0];
         end else begin
            rem_in = rem_shift[pcfm_pkg::DATA_BITS-1:0];
         end
         quo_in = {quo_ff[pcfm_pkg::DATA_BITS-2:0], ~diff[pcfm_pkg::DATA_BITS]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff | done_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/core/period_capture_frequency_meter.sv
// Top level: item handshake, result register, reference clock register.
// A tick, start or unavailable read gives its item in the cycle after acceptance.
// A read of a finished measurement with a nonzero count runs 32 serial divider
// iterations, one quotient bit each, then the result register takes the quotient.
// Throughput: one item per cycle unless a held result or a division stalls input.
// Reset: synchronous; phase goes to done, counts and captures clear, ref clock 16000000.
module period_capture_frequency_meter #(
   parameter int TIMER_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pcfm_pkg::req_item_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pcfm_pkg::rsp_item_type         rsp_data,
   input  logic                           csr_wr_en,
   input  logic [pcfm_pkg::DATA_BITS-1:0] csr_wr_data
);

   logic [pcfm_pkg::DATA_BITS-1:0] ref_clock_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   pcfm_pkg::rsp_item_type         rsp_data_ff, rsp_data_in;
   pcfm_pkg::status_type           status;
   logic                           req_accept;
   logic                           div_start;
   logic                           div_busy;
   logic                           div_done;
   logic [pcfm_pkg::DATA_BITS-1:0] div_quotient;

   assign req_stall  = div_busy | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;
   assign div_start  = req_accept && (req_data.opcode == pcfm_pkg::OP_READ)
                     && status.done && (status.elapsed != '0);

   pcfm_timer #(
      .TIMER_BITS(TIMER_BITS)
   ) u_timer (
      .clock       (clock),
      .reset       (reset),
      .item_accept (req_accept),
      .item        (req_data),
      .status      (status)
   );

   pcfm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ref_clock_ff),
      .divisor  (status.elapsed),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Hold the reference clock
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_clock_ff <= pcfm_pkg::REF_CLOCK_RESET;
      end else if (csr_wr_en) begin
         ref_clock_ff <= csr_wr_data;
      end
   end

   // Load the result register from the item or from the divider
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && !div_start) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.frequency_hz = '0;
         rsp_data_in.phase_now    = status.phase_code;
      end
      if (div_done) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.frequency_hz = div_quotient;
         rsp_data_in.phase_now    = pcfm_pkg::PHASE_DONE_CODE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A division blocks new items
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> req_stall)
      else $error("item accepted during division");

   // The result register is free when the quotient arrives
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      div_done |-> !rsp_valid_ff)
      else $error("quotient arrives while a result is pending");

   // A started division keeps the input stalled next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_start |=> div_busy)
      else $error("divider did not start");

   // A read that launches a division presents no result until the divider finishes
   a_start_no_rsp: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !rsp_valid_ff)
      else $error("result presented before division finished");

endmodule

### verif/period_capture_frequency_meter_test.sv
// Self-checking testbench for the period capture frequency meter.
`timescale 1ns / 100ps

module period_capture_frequency_meter_test;

   localparam int TIMER_BITS = 16;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DIVIDE_CYCLES = 34;
   localparam int RANDOM_ITEMS = 1950;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   pcfm_pkg::req_item_type         req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   pcfm_pkg::rsp_item_type         rsp_data;
   logic                           csr_wr_en = 1'b0;
   logic [pcfm_pkg::DATA_BITS-1:0] csr_wr_data = '0;

   // Mirror of the meter state, updated as each item is accepted
   logic [pcfm_pkg::DATA_BITS-1:0]  ref_clock_hz_q;
   logic [TIMER_BITS-1:0]           timer_q;
   logic [TIMER_BITS-1:0]           first_edge_q;
   logic [TIMER_BITS-1:0]           second_edge_q;
   logic [pcfm_pkg::COUNT_BITS-1:0] wraps_q;
   logic [pcfm_pkg::COUNT_BITS-1:0] wraps_at_stop_q;
   logic [1:0]                      phase_q;

   pcfm_pkg::rsp_item_type pending_results[$];
   int           errors = 0;
   int           cycle_count = 0;
   int           items_sent = 0;
   bit           idle_on = 1'b1;
   int           rsp_hold_left = 0;
   int           rsp_wait_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   period_capture_frequency_meter #(
      .TIMER_BITS(TIMER_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Advance the mirrored state by one item and return the result it should give
   function automatic pcfm_pkg::rsp_item_type predict_meter_result(
      input pcfm_pkg::req_item_type it);
      pcfm_pkg::rsp_item_type         res;
      logic [pcfm_pkg::DATA_BITS-1:0] span;
      logic [pcfm_pkg::DATA_BITS-1:0] first;
      logic [pcfm_pkg::DATA_BITS-1:0] second;
      res = '0;
      case (it.opcode)
         pcfm_pkg::OP_TICK: begin
            // capture the timer value held before this tick's increment
            if (it.edge_seen) begin
               if (phase_q == pcfm_pkg::PHASE_WAIT_CODE) begin
                  first_edge_q = timer_q;
                  wraps_q = '0;
                  phase_q = pcfm_pkg::PHASE_MEAS_CODE;
               end else if (phase_q == pcfm_pkg::PHASE_MEAS_CODE) begin
                  second_edge_q = timer_q;
                  wraps_at_stop_q = wraps_q;
                  phase_q = pcfm_pkg::PHASE_DONE_CODE;
               end
            end
            timer_q = timer_q + 1'b1;
            if (timer_q == '0 && phase_q == pcfm_pkg::PHASE_MEAS_CODE)
               wraps_q = wraps_q + 1'b1;
         end
         pcfm_pkg::OP_START: begin
            first_edge_q = '0;
            second_edge_q = '0;
            wraps_q = '0;
            wraps_at_stop_q = '0;
            phase_q = pcfm_pkg::PHASE_WAIT_CODE;
         end
         pcfm_pkg::OP_READ: begin
            // elapsed ticks in full 32 bits; zero count reads as zero
            if (phase_q == pcfm_pkg::PHASE_DONE_CODE) begin
               span = pcfm_pkg::DATA_BITS'(wraps_at_stop_q);
               span = span << TIMER_BITS;
               first = pcfm_pkg::DATA_BITS'(first_edge_q);
               second = pcfm_pkg::DATA_BITS'(second_edge_q);
               span = span + second - first;
               if (span != '0)
                  res.frequency_hz = ref_clock_hz_q / span;
            end
         end
         default: ;
      endcase
      res.phase_now = phase_q;
      return res;
   endfunction

   // Offer one item after a random gap when gaps are on, hold it until accepted
   task automatic send_item(input logic [1:0] opcode, input logic edge_seen);
      pcfm_pkg::req_item_type it;
      int                     gap;
      it.opcode = opcode;
      it.edge_seen = edge_seen;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_meter_result(it));
      items_sent = items_sent + 1;
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic wait_results_done();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_ref_clock(input logic [pcfm_pkg::DATA_BITS-1:0] hz);
      csr_wr_en <= 1'b1;
      csr_wr_data <= hz;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ref_clock_hz_q = hz;
   endtask

   // One clean measurement of the given number of ticks, then a read
   task automatic measure_span(input int span);
      send_item(pcfm_pkg::OP_START, 1'b0);
      send_item(pcfm_pkg::OP_TICK, 1'b1);
      repeat (span - 1) send_item(pcfm_pkg::OP_TICK, 1'b0);
      send_item(pcfm_pkg::OP_TICK, 1'b1);
      send_item(pcfm_pkg::OP_READ, 1'b0);
   endtask

   // Mostly well-formed measurements with random content, some noise and broken ones
   task automatic send_random_sequence();
      int span;
      if ($urandom_range(0, 4) == 0) begin
         send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         return;
      end
      send_item(pcfm_pkg::OP_START, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 3)) send_item(pcfm_pkg::OP_TICK, 1'b0);
      send_item(pcfm_pkg::OP_TICK, 1'b1);
      span = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 20);
      repeat (span - 1) begin
         if ($urandom_range(0, 15) == 0)
            send_item(pcfm_pkg::OP_READ, 1'($urandom_range(0, 1)));
         else if ($urandom_range(0, 31) == 0)
            send_item(OP_SPARE, 1'($urandom_range(0, 1)));
         else
            send_item(pcfm_pkg::OP_TICK, 1'b0);
      end
      // now and then leave the measurement unfinished
      if ($urandom_range(0, 9) != 0)
         send_item(pcfm_pkg::OP_TICK, 1'b1);
      repeat ($urandom_range(1, 2)) send_item(pcfm_pkg::OP_READ, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 2)) send_item(pcfm_pkg::OP_TICK, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_directed_ops();
      // zero count right after reset, edges on non-tick items
      send_item(pcfm_pkg::OP_READ, 1'b0);
      send_item(pcfm_pkg::OP_READ, 1'b1);
      send_item(pcfm_pkg::OP_TICK, 1'b1);
      send_item(OP_SPARE, 1'b0);
      send_item(OP_SPARE, 1'b1);
      send_item(pcfm_pkg::OP_START, 1'b1);
      send_item(pcfm_pkg::OP_READ, 1'b0);
      send_item(pcfm_pkg::OP_TICK, 1'b0);
      send_item(pcfm_pkg::OP_TICK, 1'b1);
      // read while still measuring
      send_item(pcfm_pkg::OP_READ, 1'b0);
      send_item(pcfm_pkg::OP_TICK, 1'b0);
      send_item(OP_SPARE, 1'b1);
      send_item(pcfm_pkg::OP_TICK, 1'b1);
      send_item(pcfm_pkg::OP_READ, 1'b0);
      // extra edge once done is ignored
      send_item(pcfm_pkg::OP_TICK, 1'b1);
      send_item(pcfm_pkg::OP_READ, 1'b1);
      // restart in the middle of a measurement
      send_item(pcfm_pkg::OP_START, 1'b0);
      send_item(pcfm_pkg::OP_TICK, 1'b1);
      send_item(pcfm_pkg::OP_START, 1'b0);
      send_item(pcfm_pkg::OP_TICK, 1'b1);
      send_item(pcfm_pkg::OP_TICK, 1'b1);
      send_item(pcfm_pkg::OP_READ, 1'b0);
      wait_results_done();
   endtask

   task automatic test_ref_clock_extremes();
      logic [pcfm_pkg::DATA_BITS-1:0] settings[3];
      settings[0] = 32'd1;
      settings[1] = 32'hFFFF_FFFF;
      settings[2] = $urandom_range(32'hFFFF_FFFF, 1);
      foreach (settings[i]) begin
         write_ref_clock(settings[i]);
         measure_span(1);
         measure_span(3);
         wait_results_done();
      end
   endtask

   // Hold off the result side long enough for the block to stall its input
   task automatic test_backpressure();
      idle_on = 1'b0;
      rsp_hold_left = 300;
      repeat (60) send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      wait_results_done();
      idle_on = 1'b1;
   endtask

   task automatic test_random_measurements();
      logic [pcfm_pkg::DATA_BITS-1:0] hz;
      int                             stop_at;
      for (int step = 0; step < 4; step++) begin
         case (step)
            0: hz = $urandom_range(32'hFFFF_FFFF, 1);
            1: hz = 32'hFFFF_FFFF;
            2: hz = $urandom_range(1000, 1);
            default: hz = pcfm_pkg::REF_CLOCK_RESET;
         endcase
         write_ref_clock(hz);
         idle_on = (step != 1);
         stop_at = items_sent + RANDOM_ITEMS / 4;
         while (items_sent < stop_at) send_random_sequence();
         wait_results_done();
      end
      idle_on = 1'b1;
   endtask

   // Result side pacing: long hold first, then a random wait per item
   always @(posedge clock) begin : rsp_pacing
      if (rsp_valid && !rsp_stall)
         rsp_wait_left = idle_on ? $urandom_range(0, 5) : 0;
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_wait_left > 0) begin
         if (rsp_valid)
            rsp_wait_left = rsp_wait_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      pcfm_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected item: frequency_hz %0d phase_now %0d",
                   rsp_data.frequency_hz, rsp_data.phase_now);
            errors = errors + 1;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.frequency_hz !== want.frequency_hz) begin
               $error("frequency_hz: expected %0d, actual %0d",
                      want.frequency_hz, rsp_data.frequency_hz);
               errors = errors + 1;
            end
            if (rsp_data.phase_now !== want.phase_now) begin
               $error("phase_now: expected %0d, actual %0d",
                      want.phase_now, rsp_data.phase_now);
               errors = errors + 1;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : run_tests
      ref_clock_hz_q = pcfm_pkg::REF_CLOCK_RESET;
      timer_q = '0;
      first_edge_q = '0;
      second_edge_q = '0;
      wraps_q = '0;
      wraps_at_stop_q = '0;
      phase_q = pcfm_pkg::PHASE_DONE_CODE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_ref_clock_extremes();
      test_backpressure();
      test_random_measurements();
      wait_results_done();
      repeat (DIVIDE_CYCLES + 6) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
